// ===== src/rbst_pkg.sv =====
// Shared types and constants for the ray versus box slab test.
package rbst_pkg;

    // Fixed word width of every distance, coordinate and reciprocal
    localparam int Q_W = 32;

    // Defaults for the top level parameters
    localparam int DEF_FRACTION_BITS = 16;
    localparam int DEF_AXES          = 3;

    // A ray load always stores three axes
    localparam int STORED_AXES = 3;
    localparam int AXIS_W      = 2;

    // Operation codes of an input word
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef logic signed [Q_W-1:0] q_t;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    typedef logic [AXIS_W-1:0] axis_t;

    // Tag that travels with a slab product: its axis and which corner it uses
    typedef struct packed {
        axis_t axis;
        logic  upper;
    } slab_tag_t;

endpackage

// ===== src/rbst_cmd_if.sv =====
// Input channel: ray load or box test word with valid/ready handshake.
interface rbst_cmd_if;
    logic          valid;
    logic          ready;
    logic          operation;
    rbst_pkg::q_t  a_x;
    rbst_pkg::q_t  a_y;
    rbst_pkg::q_t  a_z;
    rbst_pkg::q_t  b_x;
    rbst_pkg::q_t  b_y;
    rbst_pkg::q_t  b_z;
    rbst_pkg::q_t  far_limit;

    modport source (
        output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, far_limit,
        input  ready
    );

    modport sink (
        input  valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, far_limit,
        output ready
    );
endinterface

// ===== src/rbst_res_if.sv =====
// Output channel: box test result word with valid/ready handshake.
interface rbst_res_if;
    logic          valid;
    logic          ready;
    logic          hit;
    rbst_pkg::q_t  t_enter;
    rbst_pkg::q_t  t_exit;

    modport source (
        output valid, hit, t_enter, t_exit,
        input  ready
    );

    modport sink (
        input  valid, hit, t_enter, t_exit,
        output ready
    );
endinterface

// ===== src/rbst_recip_div.sv =====
// Bit-serial restoring divider that forms the saturated fixed-point reciprocal.
module rbst_recip_div #(
    parameter int FRACTION_BITS = rbst_pkg::DEF_FRACTION_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  rbst_pkg::q_t divisor,
    output logic         done,
    output rbst_pkg::q_t quot
);

    // Quotient of 2^(2F) by a magnitude of at least one needs 2F+1 bits
    localparam int QW    = 2 * FRACTION_BITS + 1;
    localparam int QX    = (QW > 33) ? QW : 33;
    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [31:0]      rem_reg,   rem_next;
    logic [QW-1:0]    quo_reg,   quo_next;
    logic [QW-1:0]    num_reg,   num_next;
    logic [31:0]      mag_reg,   mag_next;
    logic             neg_reg,   neg_next;

    logic [32:0]      trial;
    logic             fits;
    logic [QX-1:0]    qx;
    logic [31:0]      q_neg;

    // Shift in one dividend bit and subtract where the divisor fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        num_next  = num_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, num_reg[QW-1]};
        fits      = (trial >= {1'b0, mag_reg});

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            rem_next  = '0;
            quo_next  = '0;
            num_next  = {1'b1, {(QW-1){1'b0}}};
            mag_next  = divisor[31] ? 32'(-divisor) : 32'(divisor);
            neg_next  = divisor[31];
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits in 32 bits
            rem_next = fits ? 32'(trial - {1'b0, mag_reg}) : trial[31:0];
            quo_next = {quo_reg[QW-2:0], fits};
            num_next = {num_reg[QW-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        num_reg <= num_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

    // Apply the sign and saturate to the signed word range
    assign qx    = QX'(quo_reg);
    assign q_neg = 32'(-qx[31:0]);

    always_comb
    begin
        if (neg_reg)
        begin
            if ((|qx[QX-1:32]) || (qx[31] && (|qx[30:0])))
                quot = rbst_pkg::Q_MIN;
            else
                quot = $signed(q_neg);
        end
        else
        begin
            if (|qx[QX-1:31])
                quot = rbst_pkg::Q_MAX;
            else
                quot = $signed(qx[31:0]);
        end
    end

    assign done = done_reg;

endmodule

// ===== src/rbst_slab_mul.sv =====
// Shared three-stage slab unit: subtract, multiply, floor shift and saturate.
module rbst_slab_mul #(
    parameter int FRACTION_BITS = rbst_pkg::DEF_FRACTION_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rbst_pkg::slab_tag_t in_tag,
    input  rbst_pkg::q_t        corner,
    input  rbst_pkg::q_t        origin,
    input  rbst_pkg::q_t        inv,
    output logic                out_valid,
    output rbst_pkg::slab_tag_t out_tag,
    output rbst_pkg::q_t        value
);

    logic                v1_reg, v2_reg, v3_reg;
    rbst_pkg::slab_tag_t tag1_reg, tag2_reg, tag3_reg;
    logic signed [32:0]  diff_reg;
    rbst_pkg::q_t        inv_reg;
    logic signed [64:0]  prod_reg;
    rbst_pkg::q_t        res_reg;

    logic signed [32:0]  diff_next;
    logic signed [64:0]  prod_next;
    logic signed [64:0]  shifted;
    rbst_pkg::q_t        res_next;

    // Stage one: exact 33-bit corner offset
    assign diff_next = 33'(corner) - 33'(origin);

    // Stage two: exact signed product
    assign prod_next = diff_reg * inv_reg;

    // Stage three: arithmetic shift rounds toward minus infinity, then clamp
    assign shifted = prod_reg >>> FRACTION_BITS;

    always_comb
    begin
        if ((|shifted[64:31]) && !(&shifted[64:31]))
            res_next = shifted[64] ? rbst_pkg::Q_MIN : rbst_pkg::Q_MAX;
        else
            res_next = $signed(shifted[31:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= in_tag;
        tag2_reg <= tag1_reg;
        tag3_reg <= tag2_reg;
        diff_reg <= diff_next;
        inv_reg  <= inv;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign out_valid = v3_reg;
    assign out_tag   = tag3_reg;
    assign value     = res_reg;

endmodule

// ===== src/ray_box_slab_test_top.sv =====
// Top level of the ray versus axis-aligned box slab test with its sequencer.
//
// A load word (operation 0) stores the ray origin, the Q format reciprocal of
// each direction component and the far limit, and gives no result. The
// reciprocals come from the bit-serial reciprocal divider that produces one
// quotient bit per cycle for each non-zero axis (a zero component is marked
// parallel and skips the divider). A test word (operation 1) carries the box
// minimum and maximum corners and gives one result word: hit, entry and exit
// distance. Its products come from the single shared slab unit that starts
// one product per cycle and returns it after its subtract, multiply and shift
// stages. The input is not ready while a word is in work; a finished result
// waits in the output register while the next input word is taken.
module ray_box_slab_test_top #(
    parameter int FRACTION_BITS = rbst_pkg::DEF_FRACTION_BITS,
    parameter int AXES          = rbst_pkg::DEF_AXES
) (
    input  logic        clk,
    input  logic        rst_n,
    rbst_cmd_if.sink    cmd,
    rbst_res_if.source  res
);

    localparam int NA = rbst_pkg::STORED_AXES;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV_WAIT,
        S_TEST,
        S_DRAIN,
        S_FINISH
    } state_t;

    localparam rbst_pkg::axis_t LAST_TEST_AXIS = rbst_pkg::axis_t'(AXES - 1);
    localparam rbst_pkg::axis_t LAST_LOAD_AXIS = rbst_pkg::axis_t'(NA - 1);

    state_t              state_reg,   state_next;
    rbst_pkg::axis_t     axis_reg,    axis_next;
    logic                half_reg,    half_next;

    // Stored ray
    rbst_pkg::q_t        origin_reg [NA];
    rbst_pkg::q_t        origin_next [NA];
    rbst_pkg::q_t        inv_reg [NA];
    rbst_pkg::q_t        inv_next [NA];
    logic [NA-1:0]       par_reg,     par_next;
    logic [NA-1:0]       neg_reg,     neg_next;
    rbst_pkg::q_t        far_reg,     far_next;

    // Box under test and running distances
    rbst_pkg::q_t        lo_reg [NA];
    rbst_pkg::q_t        lo_next [NA];
    rbst_pkg::q_t        hi_reg [NA];
    rbst_pkg::q_t        hi_next [NA];
    rbst_pkg::q_t        enter_reg,   enter_next;
    rbst_pkg::q_t        exit_reg,    exit_next;
    rbst_pkg::q_t        lo_res_reg,  lo_res_next;
    logic                any_np_reg,  any_np_next;
    logic                par_miss_reg, par_miss_next;

    // Output word
    logic                out_valid_reg, out_valid_next;
    logic                out_hit_reg,   out_hit_next;
    rbst_pkg::q_t        out_enter_reg, out_enter_next;
    rbst_pkg::q_t        out_exit_reg,  out_exit_next;

    // Shared unit hookup
    logic                div_start;
    logic                div_done;
    rbst_pkg::q_t        div_quot;
    logic                mul_in_valid;
    rbst_pkg::slab_tag_t mul_in_tag;
    rbst_pkg::q_t        mul_corner;
    logic                mul_out_valid;
    rbst_pkg::slab_tag_t mul_out_tag;
    rbst_pkg::q_t        mul_value;

    rbst_pkg::q_t        in_a [NA];
    rbst_pkg::q_t        in_b [NA];
    rbst_pkg::q_t        t0;
    rbst_pkg::q_t        t1;
    logic                accept;
    logic                out_free;

    assign in_a[0] = cmd.a_x;
    assign in_a[1] = cmd.a_y;
    assign in_a[2] = cmd.a_z;
    assign in_b[0] = cmd.b_x;
    assign in_b[1] = cmd.b_y;
    assign in_b[2] = cmd.b_z;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign out_free  = !out_valid_reg || res.ready;

    // Slab unit issue: one corner per cycle, lower then upper for each axis
    assign mul_in_valid     = (state_reg == S_TEST);
    assign mul_in_tag.axis  = axis_reg;
    assign mul_in_tag.upper = half_reg;
    assign mul_corner       = half_reg ? hi_reg[axis_reg] : lo_reg[axis_reg];

    // Divider start for a non-parallel axis; inv_reg holds the raw direction
    assign div_start = (state_reg == S_LOAD) && (inv_reg[axis_reg] != '0);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        half_next      = half_reg;
        origin_next    = origin_reg;
        inv_next       = inv_reg;
        par_next       = par_reg;
        neg_next       = neg_reg;
        far_next       = far_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        enter_next     = enter_reg;
        exit_next      = exit_reg;
        lo_res_next    = lo_res_reg;
        any_np_next    = any_np_reg;
        par_miss_next  = par_miss_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_hit_next   = out_hit_reg;
        out_enter_next = out_enter_reg;
        out_exit_next  = out_exit_reg;
        t0             = lo_res_reg;
        t1             = mul_value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    axis_next = '0;
                    half_next = 1'b0;
                    if (cmd.operation == rbst_pkg::OP_LOAD)
                    begin
                        // Hold the raw direction until its reciprocal is ready
                        for (int a = 0; a < NA; a++)
                        begin
                            origin_next[a] = in_a[a];
                            inv_next[a]    = in_b[a];
                            par_next[a]    = (in_b[a] == '0);
                            neg_next[a]    = in_b[a][31];
                        end
                        far_next   = cmd.far_limit;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        par_miss_next = 1'b0;
                        for (int a = 0; a < NA; a++)
                        begin
                            lo_next[a] = in_a[a];
                            hi_next[a] = in_b[a];
                            if (a < AXES && par_reg[a] &&
                                (origin_reg[a] < in_a[a] || origin_reg[a] > in_b[a]))
                                par_miss_next = 1'b1;
                        end
                        enter_next  = rbst_pkg::Q_MIN;
                        exit_next   = far_reg;
                        any_np_next = 1'b0;
                        state_next  = S_TEST;
                    end
                end
            end

            S_LOAD:
            begin
                // Parallel axis keeps a zero reciprocal
                if (div_start)
                    state_next = S_DIV_WAIT;
                else if (axis_reg == LAST_LOAD_AXIS)
                    state_next = S_IDLE;
                else
                    axis_next = axis_reg + 1'b1;
            end

            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    inv_next[axis_reg] = div_quot;
                    if (axis_reg == LAST_LOAD_AXIS)
                        state_next = S_IDLE;
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end

            S_TEST:
            begin
                half_next = !half_reg;
                if (half_reg)
                begin
                    if (axis_reg == LAST_TEST_AXIS)
                        state_next = S_DRAIN;
                    else
                        axis_next = axis_reg + 1'b1;
                end
            end

            S_DRAIN:
            begin
                if (mul_out_valid && mul_out_tag.upper && mul_out_tag.axis == LAST_TEST_AXIS)
                    state_next = S_FINISH;
            end

            S_FINISH:
            begin
                // Running bounds only tighten, so one final compare covers all axes
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = !par_miss_reg && !(any_np_reg && exit_reg <= enter_reg);
                    out_enter_next = enter_reg;
                    out_exit_next  = exit_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Fold returning slab distances into the running bounds
        if (mul_out_valid)
        begin
            if (!mul_out_tag.upper)
                lo_res_next = mul_value;
            else if (!par_reg[mul_out_tag.axis])
            begin
                if (neg_reg[mul_out_tag.axis])
                begin
                    t0 = mul_value;
                    t1 = lo_res_reg;
                end
                if (t0 > enter_reg)
                    enter_next = t0;
                if (t1 < exit_reg)
                    exit_next = t1;
                any_np_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            par_reg       <= '0;
            neg_reg       <= '0;
            far_reg       <= '0;
            for (int a = 0; a < NA; a++)
            begin
                origin_reg[a] <= '0;
                inv_reg[a]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
            par_reg       <= par_next;
            neg_reg       <= neg_next;
            far_reg       <= far_next;
            origin_reg    <= origin_next;
            inv_reg       <= inv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        enter_reg     <= enter_next;
        exit_reg      <= exit_next;
        lo_res_reg    <= lo_res_next;
        any_np_reg    <= any_np_next;
        par_miss_reg  <= par_miss_next;
        out_hit_reg   <= out_hit_next;
        out_enter_reg <= out_enter_next;
        out_exit_reg  <= out_exit_next;
    end

    rbst_recip_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (inv_reg[axis_reg]),
        .done    (div_done),
        .quot    (div_quot)
    );

    rbst_slab_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_in_valid),
        .in_tag    (mul_in_tag),
        .corner    (mul_corner),
        .origin    (origin_reg[axis_reg]),
        .inv       (inv_reg[axis_reg]),
        .out_valid (mul_out_valid),
        .out_tag   (mul_out_tag),
        .value     (mul_value)
    );

    assign res.valid   = out_valid_reg;
    assign res.hit     = out_hit_reg;
    assign res.t_enter = out_enter_reg;
    assign res.t_exit  = out_exit_reg;

`ifndef SYNTHESIS
    // Slab products only come back while a box test is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_out_valid |-> (state_reg == S_TEST || state_reg == S_DRAIN))
        else $error("slab product outside a box test");

    // A reciprocal only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside a ray load");

    // A new result word follows the finish step of a test
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result word without a finished test");
`endif

endmodule

// ===== tb/tb_ray_box_slab_test_top.sv =====
// Self-checking testbench for the ray versus axis-aligned box slab test.
`timescale 1ns / 1ps

module tb_ray_box_slab_test_top;

    import rbst_pkg::*;

    localparam int FRAC = DEF_FRACTION_BITS;
    localparam int AXES = DEF_AXES;

    localparam int RANDOM_ITEMS = 1600;
    localparam int QUIET_ITEMS  = 150;
    localparam int LONG_HOLD    = 300;
    localparam int LIMIT_CYCLES = 800000;
    // worst load time plus a full box test, with some margin
    localparam int DRAIN_CYCLES = 3 * (2 * FRAC + 3) + 2 * AXES + 5 + 20;

    localparam q_t Q_ZERO = 32'sh0000_0000;
    localparam q_t Q_ONE  = 32'sh0001_0000;
    localparam q_t Q_TWO  = 32'sh0002_0000;

    typedef struct packed {
        logic op;
        q_t   ax;
        q_t   ay;
        q_t   az;
        q_t   bx;
        q_t   by;
        q_t   bz;
        q_t   far_lim;
    } slab_word_t;

    typedef struct packed {
        logic hit;
        q_t   t_enter;
        q_t   t_exit;
    } slab_result_t;

    typedef struct {
        slab_word_t   word;
        bit           has_known;
        slab_result_t known;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    rbst_cmd_if cmd_ch ();
    rbst_res_if res_ch ();

    ray_box_slab_test_top #(
        .FRACTION_BITS(FRAC),
        .AXES         (AXES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .res  (res_ch)
    );

    // Stored ray as the predictor sees it
    q_t stored_origin[3];
    q_t stored_inverse[3];
    bit stored_parallel[3];
    bit stored_negative[3];
    q_t stored_far;

    slab_result_t  expected_slab_results[$];
    directed_row_t directed_rows[$];
    slab_result_t  want_result;

    q_t scene_origin[3];
    int mismatch_count = 0;
    int item_count = 0;
    int cycle_count = 0;
    int hold_requests_made = 0;
    int hold_requests_served = 0;
    int hold_left = 0;
    int stall_left = 0;
    bit quiet_tail = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic q_t sat_q(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return q_t'(v);
    endfunction

    // Update the stored ray on a load, work out the slab result on a test
    task automatic run_slab_model(input slab_word_t w, output bit has_result,
                                  output slab_result_t r);
        q_t     lo[3];
        q_t     hi[3];
        longint d;
        longint mag;
        longint quo;
        longint t0;
        longint t1;
        longint swap;
        longint t_enter;
        longint t_exit;
        bit     hit;
        lo[0] = w.ax;
        lo[1] = w.ay;
        lo[2] = w.az;
        hi[0] = w.bx;
        hi[1] = w.by;
        hi[2] = w.bz;
        has_result = 1'b0;
        r = '0;
        if (w.op == OP_LOAD)
        begin
            for (int a = 0; a < STORED_AXES; a++)
            begin
                d = longint'(hi[a]);
                stored_origin[a]   = lo[a];
                stored_parallel[a] = (d == 0);
                stored_negative[a] = (d < 0);
                if (d == 0)
                    stored_inverse[a] = Q_ZERO;
                else
                begin
                    mag = (d < 0) ? -d : d;
                    quo = (longint'(1) <<< (2 * FRAC)) / mag;
                    stored_inverse[a] = sat_q((d < 0) ? -quo : quo);
                end
            end
            stored_far = w.far_lim;
        end
        else
        begin
            hit     = 1'b1;
            t_enter = longint'(Q_MIN);
            t_exit  = longint'(stored_far);
            for (int a = 0; a < AXES; a++)
            begin
                if (stored_parallel[a])
                begin
                    // parallel axis: only the slab containment matters
                    if (stored_origin[a] < lo[a] || stored_origin[a] > hi[a])
                        hit = 1'b0;
                end
                else
                begin
                    t0 = longint'(sat_q(((longint'(lo[a]) - longint'(stored_origin[a]))
                         * longint'(stored_inverse[a])) >>> FRAC));
                    t1 = longint'(sat_q(((longint'(hi[a]) - longint'(stored_origin[a]))
                         * longint'(stored_inverse[a])) >>> FRAC));
                    if (stored_negative[a])
                    begin
                        swap = t0;
                        t0   = t1;
                        t1   = swap;
                    end
                    if (t0 > t_enter)
                        t_enter = t0;
                    if (t1 < t_exit)
                        t_exit = t1;
                    if (t_exit <= t_enter)
                        hit = 1'b0;
                end
            end
            has_result = 1'b1;
            r.hit      = hit;
            r.t_enter  = q_t'(t_enter);
            r.t_exit   = q_t'(t_exit);
        end
    endtask

    // Offer one word, pacing the sender, and record what it should give
    task automatic send_word(input slab_word_t w, input bit has_known,
                             input slab_result_t known);
        bit           pause;
        int           gap;
        bit           produces;
        slab_result_t r;
        item_count++;
        pause = !quiet_tail && (item_count % 400 == 200);
        gap   = 0;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 8);
        if (item_count == 100 || item_count == 700 || item_count == 1300)
            hold_requests_made++;
        if (pause || gap != 0)
        begin
            @(negedge clk);
            cmd_ch.valid = 1'b0;
        end
        // hold back until every pending result has come out
        if (pause)
            while (expected_slab_results.size() != 0)
                @(posedge clk);
        if (gap > 1)
            repeat (gap - 1) @(negedge clk);
        @(negedge clk);
        cmd_ch.operation = w.op;
        cmd_ch.a_x       = w.ax;
        cmd_ch.a_y       = w.ay;
        cmd_ch.a_z       = w.az;
        cmd_ch.b_x       = w.bx;
        cmd_ch.b_y       = w.by;
        cmd_ch.b_z       = w.bz;
        cmd_ch.far_limit = w.far_lim;
        cmd_ch.valid     = 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        run_slab_model(w, produces, r);
        if (produces)
            expected_slab_results.push_back(has_known ? known : r);
    endtask

    task automatic add_load(input q_t ox, input q_t oy, input q_t oz, input q_t dx,
                            input q_t dy, input q_t dz, input q_t far_lim);
        directed_row_t row;
        row.word      = '{OP_LOAD, ox, oy, oz, dx, dy, dz, far_lim};
        row.has_known = 1'b0;
        row.known     = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_test(input q_t lx, input q_t ly, input q_t lz, input q_t hx,
                            input q_t hy, input q_t hz, input bit has_known,
                            input logic k_hit, input q_t k_enter, input q_t k_exit);
        directed_row_t row;
        row.word      = '{OP_TEST, lx, ly, lz, hx, hy, hz, Q_ZERO};
        row.has_known = has_known;
        row.known     = '{k_hit, k_enter, k_exit};
        directed_rows.push_back(row);
    endtask

    function automatic q_t any_value();
        case ($urandom_range(0, 9))
            0: return Q_MIN;
            1: return Q_MAX;
            2: return Q_ZERO;
            3: return q_t'(1);
            4: return q_t'(-1);
            default: return q_t'($urandom);
        endcase
    endfunction

    // Signed value within about +/- 2^bits raw
    function automatic q_t near_value(input int bits);
        q_t v;
        v = q_t'($urandom);
        return v >>> (31 - bits);
    endfunction

    function automatic slab_word_t random_ray(input bit noisy);
        slab_word_t w;
        q_t         org[3];
        q_t         dir[3];
        q_t         far_lim;
        for (int a = 0; a < 3; a++)
        begin
            if (noisy)
            begin
                org[a] = any_value();
                dir[a] = any_value();
            end
            else
            begin
                org[a] = near_value(22);
                dir[a] = ($urandom_range(0, 4) == 0) ? Q_ZERO : near_value(19);
            end
            scene_origin[a] = org[a];
        end
        if (noisy)
            far_lim = any_value();
        else
            case ($urandom_range(0, 3))
                0: far_lim = Q_MAX;
                1: far_lim = near_value(23);
                default: far_lim = q_t'($urandom_range(0, 1 << 28));
            endcase
        w = '{OP_LOAD, org[0], org[1], org[2], dir[0], dir[1], dir[2], far_lim};
        return w;
    endfunction

    function automatic slab_word_t random_box(input bit noisy);
        slab_word_t w;
        q_t         lo[3];
        q_t         hi[3];
        q_t         tmp;
        for (int a = 0; a < 3; a++)
        begin
            if (noisy)
            begin
                lo[a] = any_value();
                hi[a] = any_value();
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    // box around the ray origin on this axis
                    lo[a] = scene_origin[a] - q_t'($urandom_range(0, 1 << 20));
                    hi[a] = scene_origin[a] + q_t'($urandom_range(0, 1 << 20));
                end
                else
                begin
                    lo[a] = near_value(22);
                    hi[a] = lo[a] + q_t'($urandom_range(0, 1 << 21));
                end
                // now and then an inverted slab
                if ($urandom_range(0, 31) == 0)
                begin
                    tmp   = lo[a];
                    lo[a] = hi[a];
                    hi[a] = tmp;
                end
            end
        end
        w = '{OP_TEST, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], q_t'($urandom)};
        return w;
    endfunction

    // Receiver: random stall bursts, plus a long hold-off when asked
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                res_ch.ready = 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready = 1'b0;
            end
            else if (hold_requests_served != hold_requests_made)
            begin
                hold_requests_served++;
                hold_left = LONG_HOLD - 1;
                res_ch.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                res_ch.ready = 1'b0;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_slab_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual hit %0d %h %h",
                         $time, res_ch.hit, res_ch.t_enter, res_ch.t_exit);
                mismatch_count++;
            end
            else
            begin
                want_result = expected_slab_results.pop_front();
                if (res_ch.hit !== want_result.hit)
                begin
                    $display("%0t: hit mismatch, expected %0d actual %0d",
                             $time, want_result.hit, res_ch.hit);
                    mismatch_count++;
                end
                if (res_ch.t_enter !== want_result.t_enter)
                begin
                    $display("%0t: t_enter mismatch, expected %h actual %h",
                             $time, want_result.t_enter, res_ch.t_enter);
                    mismatch_count++;
                end
                if (res_ch.t_exit !== want_result.t_exit)
                begin
                    $display("%0t: t_exit mismatch, expected %h actual %h",
                             $time, want_result.t_exit, res_ch.t_exit);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ray_box_slab_test_top verification failed");
        $finish;
    end

    initial
    begin
        int            random_sent;
        int            tests;
        bit            noisy;
        directed_row_t row;

        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = OP_LOAD;
        cmd_ch.a_x       = Q_ZERO;
        cmd_ch.a_y       = Q_ZERO;
        cmd_ch.a_z       = Q_ZERO;
        cmd_ch.b_x       = Q_ZERO;
        cmd_ch.b_y       = Q_ZERO;
        cmd_ch.b_z       = Q_ZERO;
        cmd_ch.far_limit = Q_ZERO;
        for (int a = 0; a < 3; a++)
        begin
            stored_origin[a]   = Q_ZERO;
            stored_inverse[a]  = Q_ZERO;
            stored_parallel[a] = 1'b0;
            stored_negative[a] = 1'b0;
            scene_origin[a]    = Q_ZERO;
        end
        stored_far = Q_ZERO;

        // Test before any load: zero ray gives zero distances and a miss
        add_test(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1, 1'b0, Q_ZERO, Q_ZERO);
        // All axes parallel: containment only, distances stay at their start
        add_load(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_MAX);
        add_test(q_t'(-1), q_t'(-1), q_t'(-1), q_t'(1), q_t'(1), q_t'(1),
                 1, 1'b1, Q_MIN, Q_MAX);
        add_test(q_t'(1), Q_MIN, Q_MIN, q_t'(2), Q_MAX, Q_MAX, 1, 1'b0, Q_MIN, Q_MAX);
        add_test(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1, 1'b1, Q_MIN, Q_MAX);
        add_test(Q_MIN, Q_MIN, Q_MIN, q_t'(-1), q_t'(-1), q_t'(-1),
                 1, 1'b0, Q_MIN, Q_MAX);
        // Unit direction on every axis
        add_load(Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ONE, Q_ONE, 32'sh0064_0000);
        add_test(Q_ONE, Q_ONE, Q_ONE, Q_TWO, Q_TWO, Q_TWO, 1, 1'b1, Q_ONE, Q_TWO);
        add_test(32'sh00C8_0000, 32'sh00C8_0000, 32'sh00C8_0000,
                 32'sh012C_0000, 32'sh012C_0000, 32'sh012C_0000, 0, 1'b0, Q_ZERO, Q_ZERO);
        add_test(-Q_TWO, -Q_TWO, -Q_TWO, -Q_ONE, -Q_ONE, -Q_ONE, 0, 1'b0, Q_ZERO, Q_ZERO);
        // Negative direction swaps entry and exit
        add_load(Q_ZERO, Q_ZERO, Q_ZERO, -Q_ONE, -Q_ONE, -Q_ONE, Q_MAX);
        add_test(-Q_TWO, -Q_TWO, -Q_TWO, -Q_ONE, -Q_ONE, -Q_ONE, 1, 1'b1, Q_ONE, Q_TWO);
        // Saturating reciprocals and products at the field extremes
        add_load(Q_MIN, Q_MAX, Q_ZERO, q_t'(1), q_t'(-1), Q_MIN, Q_MAX);
        add_test(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 0, 1'b0, Q_ZERO, Q_ZERO);
        add_test(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 1'b0, Q_ZERO, Q_ZERO);
        // Floor rounding, a parallel middle axis and a negative far limit
        add_load(Q_ZERO, 32'sh0005_0000, Q_ZERO, Q_MAX, Q_ZERO, 32'sh0003_0000, -Q_ONE);
        add_test(q_t'(-1), 32'sh0004_0000, q_t'(-1), q_t'(1), 32'sh0006_0000, q_t'(1),
                 0, 1'b0, Q_ZERO, Q_ZERO);
        add_test(Q_ZERO, 32'sh0006_0000, Q_ZERO, Q_ZERO, 32'sh0007_0000, Q_ZERO,
                 0, 1'b0, Q_ZERO, Q_ZERO);
        // Fractional origin, mixed directions, box around the origin
        add_load(32'sh0000_8000, -32'sh0000_8000, Q_ZERO, 32'sh0000_4000, Q_ZERO,
                 -32'sh0004_0000, 32'sh03E8_0000);
        add_test(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 1'b0, Q_ZERO, Q_ZERO);
        add_test(Q_ONE, Q_ONE, Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, 0, 1'b0, Q_ZERO, Q_ZERO);

        // Hold reset low, then release it between edges
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        while (directed_rows.size() != 0)
        begin
            row = directed_rows.pop_front();
            send_word(row.word, row.has_known, row.known);
        end

        // Random scenes: mostly a ray followed by boxes near it, some noise
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            quiet_tail = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
            noisy = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) != 0)
            begin
                send_word(random_ray(noisy), 1'b0, '0);
                random_sent++;
            end
            tests = $urandom_range(1, 10);
            repeat (tests)
            begin
                send_word(random_box(noisy || $urandom_range(0, 15) == 0), 1'b0, '0);
                random_sent++;
            end
        end
        @(negedge clk);
        cmd_ch.valid = 1'b0;

        // Drain, then give the block time to show anything extra
        while (expected_slab_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ray_box_slab_test_top verification clean");
        else
            $display("ray_box_slab_test_top verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/rbst_pkg.sv
src/rbst_cmd_if.sv
src/rbst_res_if.sv
src/rbst_recip_div.sv
src/rbst_slab_mul.sv
src/ray_box_slab_test_top.sv
tb/tb_ray_box_slab_test_top.sv
